### rtl/bpp_pkg.sv
package bpp_pkg;

  localparam int unsigned STEP_DEPTH = 16;

  localparam int unsigned TickW   = 10;
  localparam int unsigned DurW    = 16;
  localparam int unsigned ElapsedW = 17;

  localparam logic [TickW-1:0] TICK_PERIOD_RST = TickW'(10);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PLAY  = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  typedef struct packed {
    logic            on;
    logic [DurW-1:0] duration;
  } step_entry_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [3:0]      entry_addr;
    logic            entry_on;
    logic [DurW-1:0] entry_duration;
    logic [3:0]      play_base;
    logic [4:0]      play_length;
    logic [7:0]      play_repeat;
    logic [1:0]      play_priority;
  } req_item_t;

  typedef struct packed {
    logic buzzer_on;
    logic is_idle;
    logic play_taken;
  } rsp_item_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    step_entry_t entry;
  } store_wr_t;

endpackage

### rtl/bpp_if.sv
interface bpp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] entry_addr;
  logic       entry_on;
  logic [15:0] entry_duration;
  logic [3:0] play_base;
  logic [4:0] play_length;
  logic [7:0] play_repeat;
  logic [1:0] play_priority;

  modport source (
    output valid, req_type, entry_addr, entry_on, entry_duration,
           play_base, play_length, play_repeat, play_priority,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_addr, entry_on, entry_duration,
           play_base, play_length, play_repeat, play_priority,
    output ready
  );
endinterface

interface bpp_rsp_if;
  logic valid;
  logic ready;
  logic buzzer_on;
  logic is_idle;
  logic play_taken;

  modport source (
    output valid, buzzer_on, is_idle, play_taken,
    input  ready
  );
  modport sink (
    input  valid, buzzer_on, is_idle, play_taken,
    output ready
  );
endinterface

### rtl/bpp_step_store.sv
module bpp_step_store #(
  parameter int unsigned STEP_DEPTH = bpp_pkg::STEP_DEPTH
) (
  input  logic                  clk_i,
  input  bpp_pkg::store_wr_t    wr_i,
  input  logic [5:0]            dur_addr_i,
  output logic [bpp_pkg::DurW-1:0] dur_o,
  input  logic [5:0]            lvl_addr_i,
  output logic                  lvl_o
);

  localparam int unsigned AddrW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;

  // Linear addresses stay below 64, so the wrap is a small constant table.
  logic [AddrW-1:0] wrap_lut [64];
  bpp_pkg::step_entry_t mem_q [STEP_DEPTH];

  for (genvar g = 0; g < 64; g++) begin : g_wrap
    assign wrap_lut[g] = AddrW'(g % STEP_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wrap_lut[{2'b00, wr_i.addr}]] <= wr_i.entry;
    end
  end

  assign dur_o = mem_q[wrap_lut[dur_addr_i]].duration;
  assign lvl_o = mem_q[wrap_lut[lvl_addr_i]].on;

endmodule

### rtl/bpp_player.sv
module bpp_player (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  bpp_pkg::req_item_t        item_i,
  input  logic [bpp_pkg::TickW-1:0] tick_period_i,
  output bpp_pkg::store_wr_t        wr_o,
  output logic [5:0]                dur_addr_o,
  input  logic [bpp_pkg::DurW-1:0]  dur_i,
  output logic [5:0]                lvl_addr_o,
  input  logic                      lvl_i,
  output bpp_pkg::rsp_item_t        rsp_o
);

  logic                          playing_q, playing_d;
  logic [3:0]                    base_q, base_d;
  logic [4:0]                    len_q, len_d;
  logic [4:0]                    pos_q, pos_d;
  logic [bpp_pkg::ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic [7:0]                    rounds_q, rounds_d;
  logic [1:0]                    prio_q, prio_d;
  logic                          drive_q, drive_d;

  logic                          taken;
  logic [3:0]                    lvl_base;
  logic [4:0]                    lvl_pos;
  logic [4:0]                    pos_inc;
  logic [bpp_pkg::ElapsedW-1:0]  el_sum;

  assign pos_inc    = pos_q + 5'd1;
  assign el_sum     = elapsed_q + bpp_pkg::ElapsedW'(tick_period_i);
  assign dur_addr_o = {2'b00, base_q} + {1'b0, pos_q};
  assign lvl_addr_o = {2'b00, lvl_base} + {1'b0, lvl_pos};

  assign wr_o.en             = fire_i && (item_i.req_type == bpp_pkg::REQ_WRITE);
  assign wr_o.addr           = item_i.entry_addr;
  assign wr_o.entry.on       = item_i.entry_on;
  assign wr_o.entry.duration = item_i.entry_duration;

  always_comb begin
    playing_d = playing_q;
    base_d    = base_q;
    len_d     = len_q;
    pos_d     = pos_q;
    elapsed_d = elapsed_q;
    rounds_d  = rounds_q;
    prio_d    = prio_q;
    drive_d   = drive_q;
    taken     = 1'b0;
    lvl_base  = base_q;
    // next level comes from the following step, or step zero on wrap
    lvl_pos   = (pos_inc < len_q) ? pos_inc : 5'd0;
    case (item_i.req_type)
      bpp_pkg::REQ_TICK: begin
        if (playing_q) begin
          if (dur_i == '0) begin
            // skip step without timing
            pos_d = pos_inc;
            if (pos_inc >= len_q) begin
              playing_d = 1'b0;
              drive_d   = 1'b0;
            end else begin
              drive_d = lvl_i;
            end
          end else if (el_sum < {1'b0, dur_i}) begin
            elapsed_d = el_sum;
          end else begin
            elapsed_d = '0;
            if (pos_inc < len_q) begin
              pos_d   = pos_inc;
              drive_d = lvl_i;
            end else if (rounds_q == '0) begin
              pos_d   = '0;
              drive_d = lvl_i;
            end else begin
              rounds_d = rounds_q - 8'd1;
              if (rounds_q != 8'd1) begin
                pos_d   = '0;
                drive_d = lvl_i;
              end else begin
                pos_d     = pos_inc;
                playing_d = 1'b0;
                drive_d   = 1'b0;
              end
            end
          end
        end
      end
      bpp_pkg::REQ_PLAY: begin
        lvl_base = item_i.play_base;
        lvl_pos  = 5'd0;
        if ((item_i.play_length != '0) &&
            (!playing_q || (item_i.play_priority >= prio_q))) begin
          base_d    = item_i.play_base;
          len_d     = item_i.play_length;
          pos_d     = '0;
          elapsed_d = '0;
          rounds_d  = item_i.play_repeat;
          prio_d    = item_i.play_priority;
          playing_d = 1'b1;
          drive_d   = lvl_i;
          taken     = 1'b1;
        end
      end
      bpp_pkg::REQ_STOP: begin
        playing_d = 1'b0;
        drive_d   = 1'b0;
        prio_d    = '0;
      end
      bpp_pkg::REQ_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.buzzer_on  = drive_d;
  assign rsp_o.is_idle    = !playing_d;
  assign rsp_o.play_taken = taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      base_q    <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      elapsed_q <= '0;
      rounds_q  <= '0;
      prio_q    <= '0;
      drive_q   <= 1'b0;
    end else if (fire_i) begin
      playing_q <= playing_d;
      base_q    <= base_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      elapsed_q <= elapsed_d;
      rounds_q  <= rounds_d;
      prio_q    <= prio_d;
      drive_q   <= drive_d;
    end
  end

endmodule

### rtl/priority_beep_pattern_player_core.sv
// Channel   Dir   Handshake            Carries
// req_i     in    valid/ready          tick, play, stop or step-store write request
// rsp_o     out   valid/ready          buzzer level, idle flag, play-taken flag
// cfg       in    cfg_we_i/cfg_data_i  tick period in ms
//
// One request per cycle sustained while rsp_o is not stalled; a response passes through
// the input register, then the result register, after its request is accepted.
// The player state and the step-store read/update sit between those two registers.
// Reset clears the control state and sets the tick period to 10 ms; the step store
// holds garbage until written and has no clearing pass.
// A stalled rsp_o holds its result; one more request waits in the input register,
// after which req_i.ready drops.
module priority_beep_pattern_player_core #(
  parameter int unsigned STEP_DEPTH = bpp_pkg::STEP_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bpp_req_if.sink                   req_i,
  bpp_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [bpp_pkg::TickW-1:0] cfg_data_i
);

  logic [bpp_pkg::TickW-1:0] tick_period_q;
  logic                      in_vld_q;
  bpp_pkg::req_item_t        item_q;
  logic                      out_vld_q;
  bpp_pkg::rsp_item_t        rsp_q;
  bpp_pkg::rsp_item_t        rsp_d;
  logic                      advance;
  bpp_pkg::store_wr_t        store_wr;
  logic [5:0]                dur_addr;
  logic [bpp_pkg::DurW-1:0]  dur_rd;
  logic [5:0]                lvl_addr;
  logic                      lvl_rd;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= bpp_pkg::TICK_PERIOD_RST;
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_period_q <= cfg_data_i;
      end
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.req_type       <= req_i.req_type;
      item_q.entry_addr     <= req_i.entry_addr;
      item_q.entry_on       <= req_i.entry_on;
      item_q.entry_duration <= req_i.entry_duration;
      item_q.play_base      <= req_i.play_base;
      item_q.play_length    <= req_i.play_length;
      item_q.play_repeat    <= req_i.play_repeat;
      item_q.play_priority  <= req_i.play_priority;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  bpp_player u_player (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .item_i        (item_q),
    .tick_period_i (tick_period_q),
    .wr_o          (store_wr),
    .dur_addr_o    (dur_addr),
    .dur_i         (dur_rd),
    .lvl_addr_o    (lvl_addr),
    .lvl_i         (lvl_rd),
    .rsp_o         (rsp_d)
  );

  bpp_step_store #(
    .STEP_DEPTH (STEP_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (store_wr),
    .dur_addr_i (dur_addr),
    .dur_o      (dur_rd),
    .lvl_addr_i (lvl_addr),
    .lvl_o      (lvl_rd)
  );

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.buzzer_on  = rsp_q.buzzer_on;
  assign rsp_o.is_idle    = rsp_q.is_idle;
  assign rsp_o.play_taken = rsp_q.play_taken;

endmodule

### rtl/bpp_checker.sv
module bpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_buzzer_on_i,
  input logic rsp_is_idle_i,
  input logic rsp_play_taken_i
);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable({rsp_buzzer_on_i, rsp_is_idle_i, rsp_play_taken_i}))
    else $error("stalled response changed");

  a_taken_plays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_play_taken_i |-> !rsp_is_idle_i)
    else $error("accepted play request left the player idle");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_is_idle_i |-> !rsp_buzzer_on_i)
    else $error("buzzer driven while idle");

endmodule

bind priority_beep_pattern_player_core bpp_checker u_bpp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_buzzer_on_i  (rsp_o.buzzer_on),
  .rsp_is_idle_i    (rsp_o.is_idle),
  .rsp_play_taken_i (rsp_o.play_taken)
);

### tb/sv/tb_priority_beep_pattern_player_core.sv
module tb_priority_beep_pattern_player_core;
  import bpp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned MAX_REPORTS = 40;

  // Tracks the expected player state and the responses still owed by the block.
  class beep_tracker;
    step_entry_t steps [STEP_DEPTH];
    int unsigned tick_ms;
    bit          active;
    logic [3:0]  base;
    logic [4:0]  len;
    int unsigned pos;
    int unsigned elapsed;
    logic [7:0]  rounds;
    logic [1:0]  prio;
    bit          level;
    rsp_item_t   expected_rsp [$];
    int unsigned n_errors;

    function new();
      tick_ms  = TICK_PERIOD_RST;
      active   = 1'b0;
      base     = '0;
      len      = '0;
      pos      = 0;
      elapsed  = 0;
      rounds   = '0;
      prio     = '0;
      level    = 1'b0;
      n_errors = 0;
    endfunction

    function step_entry_t step_at(int unsigned p);
      return steps[(int'(base) + p) % STEP_DEPTH];
    endfunction

    function void silence();
      level  = 1'b0;
      active = 1'b0;
    endfunction

    function void advance_tick();
      int unsigned dur;
      if (!active) return;
      dur = step_at(pos).duration;
      // skip a zero-length step without timing; ends playback on the last step
      if (dur == 0) begin
        pos++;
        if (pos >= len) silence();
        else level = step_at(pos).on;
        return;
      end
      elapsed += tick_ms;
      if (elapsed < dur) return;
      elapsed = 0;
      pos++;
      if (pos < len) begin
        level = step_at(pos).on;
        return;
      end
      if (rounds == 1) begin
        rounds = '0;
        silence();
      end else begin
        if (rounds != 0) rounds--;
        pos   = 0;
        level = step_at(0).on;
      end
    endfunction

    function void note_request(req_item_t it);
      rsp_item_t r;
      bit taken;
      taken = 1'b0;
      case (it.req_type)
        REQ_TICK: advance_tick();
        REQ_PLAY: begin
          if (it.play_length != 0 && (!active || it.play_priority >= prio)) begin
            base    = it.play_base;
            len     = it.play_length;
            pos     = 0;
            elapsed = 0;
            rounds  = it.play_repeat;
            prio    = it.play_priority;
            active  = 1'b1;
            level   = step_at(0).on;
            taken   = 1'b1;
          end
        end
        REQ_STOP: begin
          silence();
          prio = '0;
        end
        REQ_WRITE: begin
          steps[it.entry_addr % STEP_DEPTH].on       = it.entry_on;
          steps[it.entry_addr % STEP_DEPTH].duration = it.entry_duration;
        end
      endcase
      r.buzzer_on  = level;
      r.is_idle    = !active;
      r.play_taken = taken;
      expected_rsp.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (n_errors < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
      n_errors++;
    endtask

    task check_response(rsp_item_t got);
      rsp_item_t want;
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with no request pending");
        return;
      end
      want = expected_rsp.pop_front();
      if (got.buzzer_on !== want.buzzer_on)
        report_mismatch($sformatf("buzzer_on got %b want %b", got.buzzer_on, want.buzzer_on));
      if (got.is_idle !== want.is_idle)
        report_mismatch($sformatf("is_idle got %b want %b", got.is_idle, want.is_idle));
      if (got.play_taken !== want.play_taken)
        report_mismatch($sformatf("play_taken got %b want %b", got.play_taken, want.play_taken));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TickW-1:0] cfg_data_i;

  bpp_req_if req_if ();
  bpp_rsp_if rsp_if ();

  beep_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned rcv_stall_pct;
  int unsigned items_sent;
  int unsigned idle_cycles;

  priority_beep_pattern_player_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Randomize the receiver's willingness on each falling edge.
  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    rsp_item_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.buzzer_on  = rsp_if.buzzer_on;
      got.is_idle    = rsp_if.is_idle;
      got.play_taken = rsp_if.play_taken;
      tracker.check_response(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_req(input req_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.req_type       = it.req_type;
    req_if.entry_addr     = it.entry_addr;
    req_if.entry_on       = it.entry_on;
    req_if.entry_duration = it.entry_duration;
    req_if.play_base      = it.play_base;
    req_if.play_length    = it.play_length;
    req_if.play_repeat    = it.play_repeat;
    req_if.play_priority  = it.play_priority;
    req_if.valid          = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(it);
    items_sent++;
  endtask

  // Hold off new requests until every response is back.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tracker.expected_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_tick_period(input int unsigned ms);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = TickW'(ms);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.tick_ms = ms;
  endtask

  function automatic req_item_t random_fields();
    req_item_t it;
    it.req_type       = 2'($urandom_range(3));
    it.entry_addr     = 4'($urandom_range(15));
    it.entry_on       = 1'($urandom_range(1));
    it.entry_duration = 16'($urandom_range(65535));
    it.play_base      = 4'($urandom_range(15));
    it.play_length    = 5'($urandom_range(16));
    it.play_repeat    = 8'($urandom_range(255));
    it.play_priority  = 2'($urandom_range(3));
    return it;
  endfunction

  // Keep most durations within a few ticks so patterns actually advance.
  function automatic logic [DurW-1:0] rand_dur();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = tracker.tick_ms * 4;
    if (roll < 15) return '0;
    if (roll < 85) return DurW'($urandom_range(span, 1));
    if (roll < 96) return DurW'($urandom_range(65535, 1));
    return '1;
  endfunction

  function automatic req_item_t typed_item(input logic [1:0] kind);
    req_item_t it;
    it = random_fields();
    it.req_type = kind;
    return it;
  endfunction

  task automatic send_write(input int unsigned addr, input bit on, input int unsigned dur);
    req_item_t it;
    it = typed_item(REQ_WRITE);
    it.entry_addr     = 4'(addr);
    it.entry_on       = on;
    it.entry_duration = DurW'(dur);
    send_req(it);
  endtask

  task automatic send_play(input int unsigned b, input int unsigned n, input int unsigned rep,
                           input int unsigned pr);
    req_item_t it;
    it = typed_item(REQ_PLAY);
    it.play_base     = 4'(b);
    it.play_length   = 5'(n);
    it.play_repeat   = 8'(rep);
    it.play_priority = 2'(pr);
    send_req(it);
  endtask

  task automatic run_burst();
    req_item_t it;
    int unsigned n_wr;
    int unsigned n_tick;
    int unsigned roll;
    if ($urandom_range(99) < 40) send_req(typed_item(REQ_STOP));
    n_wr = $urandom_range(4);
    repeat (n_wr) begin
      it = typed_item(REQ_WRITE);
      it.entry_duration = rand_dur();
      send_req(it);
    end
    it = typed_item(REQ_PLAY);
    it.play_length = ($urandom_range(99) < 70) ? 5'($urandom_range(4, 1))
                                               : 5'($urandom_range(16, 1));
    roll = $urandom_range(99);
    if (roll < 50) it.play_repeat = 8'($urandom_range(3, 1));
    else if (roll < 75) it.play_repeat = '0;
    send_req(it);
    n_tick = $urandom_range(40, 4);
    repeat (n_tick) begin
      if ($urandom_range(99) < 85) begin
        send_req(typed_item(REQ_TICK));
      end else begin
        it = random_fields();
        if (it.req_type == REQ_WRITE && $urandom_range(1)) it.entry_duration = rand_dur();
        send_req(it);
      end
    end
    if ($urandom_range(99) < 8) drain();
  endtask

  initial begin
    int unsigned goal;
    tracker         = new();
    send_idle_pct   = 0;
    rcv_stall_pct   = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    rsp_if.ready    = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_TICK;
    req_if.entry_addr     = '0;
    req_if.entry_on       = 1'b0;
    req_if.entry_duration = '0;
    req_if.play_base      = '0;
    req_if.play_length    = '0;
    req_if.play_repeat    = '0;
    req_if.play_priority  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle tick, stop while idle and a zero-length play touch no store entry
    send_req(typed_item(REQ_TICK));
    send_req(typed_item(REQ_STOP));
    send_play(3, 0, 2, 3);
    // fill the whole store so no later play reads an unwritten entry
    for (int unsigned a = 0; a < STEP_DEPTH; a++) begin
      if (a == 14) send_write(a, 1'b1, 0);
      else if (a == 15) send_write(a, 1'b1, 65535);
      else send_write(a, (a % 2 == 0), 10 * (1 + a % 3));
    end
    send_play(0, 2, 1, 0);
    repeat (3) send_req(typed_item(REQ_TICK));
    // zero-length last step ends an endless pattern
    send_play(13, 2, 0, 1);
    repeat (3) send_req(typed_item(REQ_TICK));
    send_play(15, 16, 255, 3);
    send_play(0, 1, 0, 2);
    send_play(0, 1, 0, 3);
    repeat (2) send_req(typed_item(REQ_TICK));
    send_req(typed_item(REQ_STOP));
    send_play(1, 3, 2, 0);
    send_play(1, 3, 2, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          rcv_stall_pct = 0;
          set_tick_period(1);
        end
        1: begin
          send_idle_pct = 74;
          rcv_stall_pct = 0;
          set_tick_period(1000);
        end
        2: begin
          send_idle_pct = 0;
          rcv_stall_pct = 74;
          set_tick_period($urandom_range(999, 2));
        end
        default: begin
          send_idle_pct = 7;
          rcv_stall_pct = 7;
          set_tick_period($urandom_range(40, 2));
        end
      endcase
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) run_burst();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.expected_rsp.size() != 0)
      tracker.report_mismatch("requests left without a response");
    if (tracker.n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/bpp_pkg.sv
rtl/bpp_if.sv
rtl/bpp_step_store.sv
rtl/bpp_player.sv
rtl/priority_beep_pattern_player_core.sv
rtl/bpp_checker.sv
tb/sv/tb_priority_beep_pattern_player_core.sv
